[rtl/cahf_pkg.sv]
// Shared types, codes and constants of the corner apex hysteresis finder.
`timescale 1ns / 1ps
`default_nettype none
package cahf_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int MAX_REGIONS_DEF = 16;

  localparam int PROG_W    = 24;
  localparam int CURV_W    = 24;
  localparam int TOL_W     = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int RT_W      = 11;
  localparam int STATUS_W  = 2;

  localparam logic [16:0] RATIO_RST   = 17'd52429;
  localparam logic [15:0] SEP_RST     = 16'd45875;
  localparam logic [15:0] SPACING_RST = 16'd1000;
  localparam logic [23:0] TRACK_RST   = 24'd1000000;
  localparam logic [19:0] SMOOTH_RST  = 20'd5000;
  localparam logic [1:0]  TDIR_RST    = 2'd1;
  localparam logic [16:0] RATIO_ONE   = 17'd65536;
  localparam logic [23:0] CURV_MIN    = 24'h800000;
  localparam logic [23:0] CURV_MAX    = 24'h7FFFFF;
  localparam logic [RT_W-1:0] RT_SAT  = 11'd2047;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_RATIO = 3'd0,
    CFG_SEP_RATIO    = 3'd1,
    CFG_SPACING      = 3'd2,
    CFG_TRACK_LEN    = 3'd3,
    CFG_SMOOTHING    = 3'd4,
    CFG_CORNER_START = 3'd5,
    CFG_CORNER_END   = 3'd6,
    CFG_TURN_DIR     = 3'd7
  } cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_RESOLVED     = 2'd0,
    ST_INSUFFICIENT = 2'd1,
    ST_MULTIPLE     = 2'd2,
    ST_INVALID      = 2'd3
  } status_t;

  typedef enum logic {
    KIND_CANDIDATE = 1'b0,
    KIND_FINAL     = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CHK,
    S_FF_RD,
    S_FF_USE,
    S_W1_RD,
    S_W1_USE,
    S_GEO,
    S_W2_RD,
    S_W2_USE,
    S_EMS,
    S_EM_RD,
    S_EM_MUL,
    S_EM_SUM,
    S_EM_DIV,
    S_OUT
  } state_t;

  // Sign curvature by turn direction; negating the most negative value saturates.
  function automatic logic signed [CURV_W-1:0] turn_value(
    input logic signed [CURV_W-1:0] c,
    input logic                     neg
  );
    logic signed [CURV_W-1:0] r;
    begin
      if (!neg) begin
        r = c;
      end else if (c == CURV_MIN) begin
        r = CURV_MAX;
      end else begin
        r = -c;
      end
      return r;
    end
  endfunction

endpackage
`default_nettype wire

[rtl/cahf_in_if.sv]
// Sample channel: valid/ready handshake carrying one lap sample.
`timescale 1ns / 1ps
`default_nettype none
interface cahf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [cahf_pkg::PROG_W-1:0]          sample_progress;
  logic signed [cahf_pkg::CURV_W-1:0]   sample_curvature;
  logic                                 last_sample;

  modport source (output valid, output sample_progress, output sample_curvature,
                  output last_sample, input ready);
  modport sink (input valid, input sample_progress, input sample_curvature,
                input last_sample, output ready);
endinterface
`default_nettype wire

[rtl/cahf_out_if.sv]
// Result channel: valid/ready handshake carrying one candidate or verdict.
`timescale 1ns / 1ps
`default_nettype none
interface cahf_out_if;
  logic                            valid;
  logic                            ready;
  logic                            result_kind;
  logic [cahf_pkg::PROG_W-1:0]     position;
  logic [cahf_pkg::TOL_W-1:0]      tolerance;
  logic [cahf_pkg::STATUS_W-1:0]   status;
  logic                            broad_peak;
  logic                            last_result;

  modport source (output valid, output result_kind, output position, output tolerance,
                  output status, output broad_peak, output last_result, input ready);
  modport sink (input valid, input result_kind, input position, input tolerance,
                input status, input broad_peak, input last_result, output ready);
endinterface
`default_nettype wire

[rtl/corner_apex_hysteresis_finder.sv]
// Corner apex finder: top level with sequencer, region store and result register.
//
// Samples of one lap load at one word per cycle into the sample memory; the
// word marked last starts the evaluation and the input stays not ready until
// the final verdict is handed to the output register. Evaluation walks the
// sample memory in three passes (find corner start, peak walk, hysteresis walk),
// reading each visited sample from the registered memory port before using it.
// Each emitted midpoint is then wrapped by the track length in the bit-serial
// remainder unit, which works through the midpoint sum of SW bits (AW+17 bits,
// 27 at the default depth). Memories need no clearing pass after reset. The
// user must write configuration only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module corner_apex_hysteresis_finder #(
  parameter int MAX_SAMPLES = cahf_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_REGIONS = cahf_pkg::MAX_REGIONS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cahf_in_if.sink                        in_chan,
  cahf_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [cahf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [cahf_pkg::CFG_W-1:0]     cfg_wdata
);
  import cahf_pkg::*;

  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int RIW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int RCW = $clog2(MAX_REGIONS + 1);
  localparam int PW  = AW + 16;
  localparam int SW  = PW + 1;
  localparam int TW  = PW + 3;
  localparam int RGW = PROG_W + 2 * AW;
  localparam int MW  = PROG_W + CURV_W;
  localparam int EW  = 41;

  // configuration registers
  logic [16:0] ratio_r;
  logic [15:0] sep_r;
  logic [15:0] spacing_r;
  logic [23:0] track_r;
  logic [19:0] smooth_r;
  logic [23:0] cstart_r;
  logic [23:0] cend_r;
  logic [1:0]  tdir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r   <= RATIO_RST;
      sep_r     <= SEP_RST;
      spacing_r <= SPACING_RST;
      track_r   <= TRACK_RST;
      smooth_r  <= SMOOTH_RST;
      cstart_r  <= '0;
      cend_r    <= '0;
      tdir_r    <= TDIR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_REGION_RATIO: ratio_r   <= cfg_wdata[16:0];
        CFG_SEP_RATIO:    sep_r     <= cfg_wdata[15:0];
        CFG_SPACING:      spacing_r <= cfg_wdata[15:0];
        CFG_TRACK_LEN:    track_r   <= cfg_wdata[23:0];
        CFG_SMOOTHING:    smooth_r  <= cfg_wdata[19:0];
        CFG_CORNER_START: cstart_r  <= cfg_wdata[23:0];
        CFG_CORNER_END:   cend_r    <= cfg_wdata[23:0];
        CFG_TURN_DIR:     tdir_r    <= cfg_wdata[1:0];
      endcase
    end
  end

  state_t state_r, state_nxt;

  logic [CW-1:0]            count_r;
  logic                     ovf_r;
  logic [AW-1:0]            idx_r;
  logic [CW-1:0]            step_r;
  logic [CW-1:0]            cnt_r;
  logic [AW-1:0]            first_r;
  logic signed [CURV_W-1:0] peak_r;
  logic [EW-1:0]            enter_r;
  logic [EW-1:0]            leave_r;
  logic [RT_W-1:0]          rt_r;
  logic                     open_r;
  logic [PROG_W-1:0]        cur_p_r;
  logic [AW-1:0]            cur_first_r;
  logic [RCW-1:0]           em_r;
  logic                     fin_r;
  logic [PROG_W-1:0]        p_r;
  logic [PW-1:0]            dw_r;
  logic [TOL_W-1:0]         tol_r;
  logic                     broad_r;

  logic                     pend_kind_r;
  logic [PROG_W-1:0]        pend_pos_r;
  logic [TOL_W-1:0]         pend_tol_r;
  logic [STATUS_W-1:0]      pend_status_r;
  logic                     pend_broad_r;
  logic                     pend_last_r;

  logic                     out_valid_r;
  logic                     out_kind_r;
  logic [PROG_W-1:0]        out_pos_r;
  logic [TOL_W-1:0]         out_tol_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic                     out_broad_r;
  logic                     out_last_r;

  // sample memory
  logic          mem_we;
  logic          mem_re;
  logic [MW-1:0] mem_rdata;

  cahf_sample_mem #(
    .DEPTH (MAX_SAMPLES),
    .WIDTH (MW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_chan.sample_progress, in_chan.sample_curvature}),
    .re    (mem_re),
    .raddr (idx_r),
    .rdata (mem_rdata)
  );

  logic [PROG_W-1:0]        rd_p;
  logic signed [CURV_W-1:0] rd_c;
  logic signed [CURV_W-1:0] v;
  assign rd_p = mem_rdata[MW-1 -: PROG_W];
  assign rd_c = $signed(mem_rdata[CURV_W-1:0]);
  assign v    = turn_value(rd_c, tdir_r[1]);

  // region store: first progress, first and last walk index of each region
  logic [RGW-1:0] rg_mem [MAX_REGIONS];
  logic [RGW-1:0] rg_q;
  logic           rg_we;
  logic [RIW-1:0] rg_waddr;
  logic [RGW-1:0] rg_wdata;
  logic           rg_re;
  logic [RIW-1:0] rg_raddr;

  always_ff @(posedge clk) begin
    if (rg_we) begin
      rg_mem[rg_waddr] <= rg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rg_re) begin
      rg_q <= rg_mem[rg_raddr];
    end
  end

  // remainder unit for wrapping positions
  logic          div_start;
  logic          div_busy;
  logic          div_done;
  logic [23:0]   div_rem;
  logic [SW-1:0] mid_sum;

  assign mid_sum = SW'(p_r) + SW'(dw_r >> 1);

  cahf_mod_unit #(
    .NUM_W (SW)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mid_sum),
    .den   (track_r),
    .busy  (div_busy),
    .done  (div_done),
    .rem   (div_rem)
  );

  // decisions
  logic in_acc;
  logic out_free;
  logic invalid;
  logic geo_bad;
  logic inside_p;
  logic idx_wrap;
  logic [AW-1:0] idx_next;
  logic w1_end;
  logic w2_end;
  logic em_more;
  logic signed [EW:0] t_val;
  logic t_ge_enter;
  logic t_lt_leave;
  logic open_new;
  logic close_now;
  logic extend;
  logic [RT_W-1:0] rt_m1;
  logic [AW-1:0]   walk_i;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign invalid = ovf_r || (count_r < CW'(4)) || (spacing_r == '0) || (track_r == '0)
                 || (cstart_r > track_r) || (cend_r > track_r) || (cstart_r == cend_r)
                 || (sep_r == '0) || ({1'b0, sep_r} >= ratio_r) || (ratio_r > RATIO_ONE);
  assign geo_bad = (cnt_r < CW'(3)) || (peak_r <= 0) || (tdir_r == 2'd0);

  assign inside_p = (cstart_r <= cend_r) ? ((rd_p >= cstart_r) && (rd_p < cend_r))
                                         : ((rd_p >= cstart_r) || (rd_p < cend_r));
  assign idx_wrap = (CW'(idx_r) + CW'(1)) == count_r;
  assign idx_next = idx_wrap ? '0 : idx_r + AW'(1);
  assign w1_end   = (step_r + CW'(1)) == count_r;
  assign w2_end   = (step_r + CW'(1)) == cnt_r;
  assign em_more  = (RT_W'(em_r) < rt_r) && (em_r < RCW'(MAX_REGIONS));

  assign t_val      = $signed({{2{v[CURV_W-1]}}, v, 16'h0000});
  assign t_ge_enter = t_val >= $signed({1'b0, enter_r});
  assign t_lt_leave = t_val < $signed({1'b0, leave_r});
  assign open_new   = !open_r && t_ge_enter;
  assign close_now  = open_r && t_lt_leave;
  assign extend     = open_r && !t_lt_leave && t_ge_enter;
  assign rt_m1      = rt_r - RT_W'(1);
  assign walk_i     = step_r[AW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:   if (in_acc && in_chan.last_sample) state_nxt = S_CHK;
      S_CHK:    state_nxt = invalid ? S_OUT : S_FF_RD;
      S_FF_RD:  state_nxt = S_FF_USE;
      S_FF_USE: state_nxt = ((rd_p >= cstart_r) || idx_wrap) ? S_W1_RD : S_FF_RD;
      S_W1_RD:  state_nxt = S_W1_USE;
      S_W1_USE: state_nxt = (!inside_p || w1_end) ? S_GEO : S_W1_RD;
      S_GEO:    state_nxt = geo_bad ? S_OUT : S_W2_RD;
      S_W2_RD:  state_nxt = S_W2_USE;
      S_W2_USE: state_nxt = w2_end ? S_EMS : S_W2_RD;
      S_EMS:    state_nxt = (em_more || (rt_r == RT_W'(1))) ? S_EM_RD : S_OUT;
      S_EM_RD:  state_nxt = S_EM_MUL;
      S_EM_MUL: state_nxt = S_EM_SUM;
      S_EM_SUM: state_nxt = S_EM_DIV;
      S_EM_DIV: if (div_done) state_nxt = S_OUT;
      S_OUT:    if (out_free) state_nxt = pend_last_r ? S_LOAD : S_EMS;
    endcase
  end

  // control outputs
  always_comb begin
    in_chan.ready = (state_r == S_LOAD);
    mem_we        = in_acc && (count_r < CW'(MAX_SAMPLES));
    mem_re        = (state_r == S_FF_RD) || (state_r == S_W1_RD) || (state_r == S_W2_RD);
    rg_re         = (state_r == S_EM_RD);
    rg_raddr      = fin_r ? '0 : em_r[RIW-1:0];
    div_start     = (state_r == S_EM_SUM);
    rg_we         = (state_r == S_W2_USE)
                  && ((open_new && (rt_r < RT_W'(MAX_REGIONS)))
                   || (extend && (rt_r <= RT_W'(MAX_REGIONS))));
    rg_waddr      = open_new ? rt_r[RIW-1:0] : rt_m1[RIW-1:0];
    rg_wdata      = open_new ? {rd_p, walk_i, walk_i} : {cur_p_r, cur_first_r, walk_i};
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      rt_r        <= '0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (count_r < CW'(MAX_SAMPLES)) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (state_r == S_GEO) begin
        rt_r   <= '0;
        open_r <= 1'b0;
      end
      if (state_r == S_W2_USE) begin
        if (open_new) begin
          if (rt_r != RT_SAT) rt_r <= rt_r + RT_W'(1);
          open_r <= 1'b1;
        end else if (close_now) begin
          open_r <= 1'b0;
        end
      end
      if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
        if (pend_last_r) begin
          // verdict delivered: empty the store
          count_r <= '0;
          ovf_r   <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_LOAD: begin
        idx_r <= '0;
      end
      S_CHK: begin
        pend_kind_r   <= KIND_FINAL;
        pend_pos_r    <= '0;
        pend_tol_r    <= '0;
        pend_status_r <= ST_INVALID;
        pend_broad_r  <= 1'b0;
        pend_last_r   <= 1'b1;
      end
      S_FF_USE: begin
        step_r <= '0;
        cnt_r  <= '0;
        peak_r <= '0;
        if (rd_p >= cstart_r) begin
          first_r <= idx_r;
        end else if (idx_wrap) begin
          first_r <= '0;
          idx_r   <= '0;
        end else begin
          idx_r <= idx_r + AW'(1);
        end
      end
      S_W1_USE: begin
        if (inside_p) begin
          cnt_r <= cnt_r + CW'(1);
          if (v > peak_r) peak_r <= v;
        end
        step_r <= step_r + CW'(1);
        idx_r  <= idx_next;
      end
      S_GEO: begin
        idx_r         <= first_r;
        step_r        <= '0;
        em_r          <= '0;
        fin_r         <= 1'b0;
        enter_r       <= EW'(ratio_r) * EW'(peak_r[CURV_W-2:0]);
        leave_r       <= EW'(sep_r) * EW'(peak_r[CURV_W-2:0]);
        pend_kind_r   <= KIND_FINAL;
        pend_pos_r    <= '0;
        pend_tol_r    <= '0;
        pend_status_r <= ST_INSUFFICIENT;
        pend_broad_r  <= 1'b0;
        pend_last_r   <= 1'b1;
      end
      S_W2_USE: begin
        step_r <= step_r + CW'(1);
        idx_r  <= idx_next;
        if (open_new) begin
          cur_p_r     <= rd_p;
          cur_first_r <= walk_i;
        end
      end
      S_EMS: begin
        if (!em_more) begin
          if (rt_r == RT_W'(1)) begin
            fin_r <= 1'b1;
          end else begin
            pend_kind_r   <= KIND_FINAL;
            pend_pos_r    <= '0;
            pend_tol_r    <= '0;
            pend_status_r <= ST_MULTIPLE;
            pend_broad_r  <= 1'b0;
            pend_last_r   <= 1'b1;
          end
        end
      end
      S_EM_MUL: begin
        p_r  <= rg_q[RGW-1 -: PROG_W];
        dw_r <= PW'(rg_q[AW-1:0] - rg_q[2*AW-1:AW]) * PW'(spacing_r);
      end
      S_EM_SUM: begin
        logic [TW-1:0] base2;
        logic [TW-1:0] wide2;
        logic [TW-1:0] tol2;
        logic [TW-1:0] half;
        base2 = TW'({smooth_r, 1'b0}) + TW'({spacing_r, 1'b0});
        wide2 = TW'(dw_r) + TW'({spacing_r, 1'b0});
        tol2  = (wide2 > base2) ? wide2 : base2;
        half  = (tol2 + TW'(1)) >> 1;
        // saturate to the field range
        tol_r   <= (half > TW'(24'hFFFFFF)) ? 24'hFFFFFF : half[TOL_W-1:0];
        broad_r <= TW'(dw_r) > base2;
      end
      S_EM_DIV: begin
        if (div_done) begin
          pend_kind_r   <= fin_r ? KIND_FINAL : KIND_CANDIDATE;
          pend_pos_r    <= div_rem;
          pend_tol_r    <= fin_r ? tol_r : '0;
          pend_status_r <= ST_RESOLVED;
          pend_broad_r  <= fin_r ? broad_r : 1'b0;
          pend_last_r   <= fin_r;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_kind_r   <= pend_kind_r;
          out_pos_r    <= pend_pos_r;
          out_tol_r    <= pend_tol_r;
          out_status_r <= pend_status_r;
          out_broad_r  <= pend_broad_r;
          out_last_r   <= pend_last_r;
          if (!pend_last_r) em_r <= em_r + RCW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_kind = out_kind_r;
  assign out_chan.position    = out_pos_r;
  assign out_chan.tolerance   = out_tol_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.broad_peak  = out_broad_r;
  assign out_chan.last_result = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  a_div_idle_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> !div_busy)
    else $error("remainder unit busy while loading samples");

  a_region_present: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EM_RD) |-> (rt_r != '0))
    else $error("region read without any region found");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !out_free) |=> (state_r == S_OUT))
    else $error("result dropped while output word waits");

endmodule
`default_nettype wire

[rtl/cahf_sample_mem.sv]
// Sample store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module cahf_sample_mem #(
  parameter int DEPTH = cahf_pkg::MAX_SAMPLES_DEF,
  parameter int WIDTH = cahf_pkg::PROG_W + cahf_pkg::CURV_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[rtl/cahf_mod_unit.sv]
// Bit-serial remainder unit: num mod den, one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module cahf_mod_unit #(
  parameter int NUM_W = 27
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [NUM_W-1:0]            num,
  input  logic [cahf_pkg::PROG_W-1:0] den,
  output logic                        busy,
  output logic                        done,
  output logic [cahf_pkg::PROG_W-1:0] rem
);
  import cahf_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  num_r;
  logic [PROG_W:0]   rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [PROG_W:0]   shifted;

  assign shifted = {rem_r[PROG_W-1:0], num_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      // subtract when the partial remainder reaches the divisor
      if (shifted >= {1'b0, den}) begin
        rem_r <= shifted - {1'b0, den};
      end else begin
        rem_r <= shifted;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r[PROG_W-1:0];
endmodule
`default_nettype wire

[sim/apex_checker.sv]
// Checker for the corner apex finder: watches the channels, predicts results, compares.
`timescale 1ns / 1ps
`default_nettype none
module apex_checker
  import cahf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  cahf_in_if                   in_mon,
  cahf_out_if                  out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending,
  output int                   words_checked
);

  typedef struct packed {
    kind_t              kind;
    logic [PROG_W-1:0]  position;
    logic [TOL_W-1:0]   tolerance;
    status_t            status;
    logic               broad_peak;
    logic               last_result;
  } apex_word_t;

  localparam int NS = MAX_SAMPLES_DEF;
  localparam int NR = MAX_REGIONS_DEF;

  // register copy
  logic [16:0] ratio_enter;
  logic [15:0] ratio_leave;
  logic [15:0] spacing;
  logic [23:0] track_len;
  logic [19:0] smoothing;
  logic [23:0] corner_lo;
  logic [23:0] corner_hi;
  logic [1:0]  turn_dir;

  // lap store
  logic [PROG_W-1:0]        lap_prog [NS];
  logic signed [CURV_W-1:0] lap_curv [NS];
  int unsigned              lap_count;
  bit                       lap_overflow;

  int unsigned walk_idx [NS];
  longint      walk_turn [NS];
  int unsigned reg_first [NR];
  int unsigned reg_last [NR];

  apex_word_t expected_q[$];

  task automatic report(string what, longint got, longint want);
    $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void push_word(kind_t k, longint pos, longint tol, status_t st,
                                    logic broad, logic last);
    apex_word_t w;
    w.kind = k;
    w.position = pos[23:0];
    w.tolerance = tol[23:0];
    w.status = st;
    w.broad_peak = broad;
    w.last_result = last;
    expected_q.push_back(w);
  endfunction

  function automatic bit in_corner(logic [23:0] p);
    if (corner_lo <= corner_hi) return p >= corner_lo && p < corner_hi;
    return p >= corner_lo || p < corner_hi;
  endfunction

  function automatic longint region_mid(int unsigned r);
    longint p, d;
    p = lap_prog[walk_idx[reg_first[r]]];
    d = reg_last[r] - reg_first[r];
    return ((2 * p + d * spacing) / 2) % track_len;
  endfunction

  function automatic void predict_lap();
    int unsigned n, first, cnt, idx, total, kept;
    int dir;
    longint peak, enter, leave, t, v, d, dw, base2, wide2, tol2, tol;
    bit open;
    n = lap_count;
    first = 0;
    cnt = 0;
    peak = 0;
    open = 0;
    total = 0;
    if (lap_overflow || n < 4 || spacing == 0 || track_len == 0 || corner_lo > track_len ||
        corner_hi > track_len || corner_lo == corner_hi || ratio_leave == 0 ||
        ratio_leave >= ratio_enter || ratio_enter > RATIO_ONE) begin
      push_word(KIND_FINAL, 0, 0, ST_INVALID, 0, 1);
      return;
    end
    dir = (turn_dir == 0) ? 0 : ((turn_dir == 1) ? 1 : -1);
    for (int i = 0; i < n; i++) begin
      if (lap_prog[i] >= corner_lo) begin
        first = i;
        break;
      end
    end
    idx = first;
    for (int w = 0; w < n; w++) begin
      if (!in_corner(lap_prog[idx])) break;
      v = lap_curv[idx];
      if (dir < 0) v = (v == -8388608) ? 8388607 : -v;
      walk_idx[cnt] = idx;
      walk_turn[cnt] = v;
      cnt++;
      if (v > peak) peak = v;
      idx = (idx + 1 == n) ? 0 : idx + 1;
    end
    if (cnt < 3 || peak <= 0 || dir == 0) begin
      push_word(KIND_FINAL, 0, 0, ST_INSUFFICIENT, 0, 1);
      return;
    end
    enter = longint'(ratio_enter) * peak;
    leave = longint'(ratio_leave) * peak;
    for (int i = 0; i < cnt; i++) begin
      t = walk_turn[i] * 65536;
      if (!open && t >= enter) begin
        if (total < NR) begin
          reg_first[total] = i;
          reg_last[total] = i;
        end
        if (total < 2047) total++;
        open = 1;
      end else if (open && t < leave) begin
        open = 0;
      end else if (open && t >= enter) begin
        if (total <= NR) reg_last[total - 1] = i;
      end
    end
    kept = (total < NR) ? total : NR;
    for (int i = 0; i < kept; i++) push_word(KIND_CANDIDATE, region_mid(i), 0, ST_RESOLVED, 0, 0);
    if (total != 1) begin
      push_word(KIND_FINAL, 0, 0, ST_MULTIPLE, 0, 1);
      return;
    end
    d = reg_last[0] - reg_first[0];
    dw = d * spacing;
    base2 = 2 * (longint'(smoothing) + spacing);
    wide2 = dw + 2 * longint'(spacing);
    tol2 = (wide2 > base2) ? wide2 : base2;
    tol = (tol2 + 1) / 2;
    if (tol > 16777215) tol = 16777215;
    push_word(KIND_FINAL, region_mid(0), tol, ST_RESOLVED, dw > base2, 1);
  endfunction

  always @(posedge clk) begin
    apex_word_t w;
    if (!rst_n) begin
      ratio_enter <= RATIO_RST;
      ratio_leave <= SEP_RST;
      spacing <= SPACING_RST;
      track_len <= TRACK_RST;
      smoothing <= SMOOTH_RST;
      corner_lo <= '0;
      corner_hi <= '0;
      turn_dir <= TDIR_RST;
      lap_count = 0;
      lap_overflow = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_REGION_RATIO: ratio_enter <= cfg_wdata[16:0];
          CFG_SEP_RATIO:    ratio_leave <= cfg_wdata[15:0];
          CFG_SPACING:      spacing <= cfg_wdata[15:0];
          CFG_TRACK_LEN:    track_len <= cfg_wdata[23:0];
          CFG_SMOOTHING:    smoothing <= cfg_wdata[19:0];
          CFG_CORNER_START: corner_lo <= cfg_wdata[23:0];
          CFG_CORNER_END:   corner_hi <= cfg_wdata[23:0];
          CFG_TURN_DIR:     turn_dir <= cfg_wdata[1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (lap_count < NS) begin
          lap_prog[lap_count] = in_mon.sample_progress;
          lap_curv[lap_count] = in_mon.sample_curvature;
          lap_count++;
        end else begin
          lap_overflow = 1;
        end
        if (in_mon.last_sample) begin
          predict_lap();
          lap_count = 0;
          lap_overflow = 0;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        words_checked++;
        if (expected_q.size() == 0) begin
          report("unexpected result word, position", out_mon.position, 0);
        end else begin
          w = expected_q.pop_front();
          if (out_mon.result_kind !== w.kind) report("result_kind", out_mon.result_kind, w.kind);
          if (out_mon.position !== w.position) report("position", out_mon.position, w.position);
          if (out_mon.tolerance !== w.tolerance)
            report("tolerance", out_mon.tolerance, w.tolerance);
          if (out_mon.status !== w.status) report("status", out_mon.status, w.status);
          if (out_mon.broad_peak !== w.broad_peak)
            report("broad_peak", out_mon.broad_peak, w.broad_peak);
          if (out_mon.last_result !== w.last_result)
            report("last_result", out_mon.last_result, w.last_result);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule
`default_nettype wire

[sim/tb_corner_apex_hysteresis_finder.sv]
// Testbench top for the corner apex finder: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_corner_apex_hysteresis_finder;
  import cahf_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  int fail_count, pending, words_checked;
  int words_sent, laps_sent;
  int hold_asks;
  bit no_gaps;
  longint cur_track, cur_spacing;

  cahf_in_if  in_chan ();
  cahf_out_if out_chan ();

  corner_apex_hysteresis_finder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  apex_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .words_checked(words_checked)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int g;
    int holds_done;
    holds_done = 0;
    out_chan.ready = 0;
    @(posedge clk);
    forever begin
      if (hold_asks != holds_done) begin
        holds_done++;
        out_chan.ready <= 0;
        repeat (3000) @(posedge clk);
      end else begin
        g = pick_gap();
        if (g > 0) begin
          out_chan.ready <= 0;
          repeat (g) @(posedge clk);
        end
      end
      out_chan.ready <= 1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic set_config(int unsigned rr, int unsigned sr, int unsigned sp, int unsigned tl,
                            int unsigned sm, int unsigned cs, int unsigned ce, int unsigned td);
    int unsigned vals [8];
    vals = '{rr, sr, sp, tl, sm, cs, ce, td};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1;
      cfg_idx <= cfg_idx_t'(i);
      cfg_wdata <= CFG_W'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 0;
    cur_track = tl;
    cur_spacing = sp;
    @(posedge clk);
  endtask

  task automatic send_word(logic [23:0] p, logic [23:0] c, logic last);
    int g;
    in_chan.valid <= 1;
    in_chan.sample_progress <= p;
    in_chan.sample_curvature <= c;
    in_chan.last_sample <= last;
    do @(posedge clk); while (!in_chan.ready);
    words_sent++;
    if (last) laps_sent++;
    g = pick_gap();
    if (g > 0) begin
      in_chan.valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // drain all expected results, then let the block settle before a register write
  task automatic wait_idle();
    in_chan.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // mode 0: random content, mode 1: leveled bumps, mode 2: alternating peaks
  task automatic run_lap(int n, int mode, bit negate);
    longint off, p, hi, c;
    off = $urandom_range(0, 1000000);
    hi = $urandom_range(1000, 8388607);
    for (int i = 0; i < n; i++) begin
      if (cur_track > 0 && cur_spacing > 0) p = (off + i * cur_spacing) % cur_track;
      else p = $urandom_range(0, 16777215);
      if (mode == 0) begin
        c = $signed(24'($urandom()));
        p = (($urandom_range(0, 3) == 0) ? $urandom_range(0, 16777215) : p);
      end else if (mode == 2) begin
        c = (i % 2 == 0) ? hi : -hi;
      end else begin
        case ($urandom_range(0, 7))
          0, 1, 2: c = hi - $urandom_range(0, int'(hi / 16));
          3:       c = hi * 7 / 8;
          4:       c = hi * 3 / 4;
          5:       c = hi / 2;
          6:       c = $urandom_range(0, 2000);
          default: c = -longint'($urandom_range(0, 8388607));
        endcase
        if (negate) c = -c;
      end
      send_word(p[23:0], c[23:0], i == n - 1);
    end
  endtask

  task automatic random_phase();
    int unsigned rr, sr, sp, tl, sm, cs, ce, td;
    longint t;
    rr = ($urandom_range(0, 5) == 0) ? 65536 : $urandom_range(2, 65536);
    sr = ($urandom_range(0, 5) == 0) ? rr - 1 : $urandom_range(1, rr - 1);
    if (sr > 65535) sr = 65535;
    sp = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 2000);
    t = longint'(sp) * $urandom_range(6, 40);
    tl = (t > 16777215 || $urandom_range(0, 9) == 0) ? 16777215 : 32'(t);
    sm = $urandom_range(0, 1048575) >> $urandom_range(0, 20);
    cs = $urandom_range(0, tl);
    ce = $urandom_range(0, tl);
    td = $urandom_range(0, 3);
    if (td == 0 && $urandom_range(0, 1)) td = 1;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 5))
        0: sp = 0;
        1: tl = 0;
        2: sr = 0;
        3: sr = (rr > 65535) ? 65535 : rr;
        4: rr = $urandom_range(65537, 131071);
        default: cs = tl + 1;
      endcase
    end
    set_config(rr, sr, sp, tl, sm, cs, ce, td);
    repeat ($urandom_range(1, 4)) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      run_lap(($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(4, 40),
              ($urandom_range(0, 4) == 0) ? 0 : 1, td >= 2);
    end
    no_gaps = 0;
    wait_idle();
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_chan.valid = 0;
    in_chan.sample_progress = '0;
    in_chan.sample_curvature = '0;
    in_chan.last_sample = 0;
    words_sent = 0;
    laps_sent = 0;
    no_gaps = 0;
    hold_asks = 0;
    cur_track = 1000000;
    cur_spacing = 1000;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset registers: start equals end, so the lap is rejected
    send_word(24'd0, CURV_MIN, 0);
    send_word(24'hFFFFFF, CURV_MAX, 0);
    send_word(24'd0, 24'd0, 0);
    send_word(24'hFFFFFF, 24'hFFFFFF, 1);
    wait_idle();
    // negative turn with the most negative curvature, one region
    set_config(52429, 45875, 1000, 1000000, 5000, 0, 1000000, 3);
    send_word(24'd0, -24'sd100, 0);
    send_word(24'd1000, -24'sd5000, 0);
    send_word(24'd2000, CURV_MIN, 0);
    send_word(24'd3000, CURV_MIN, 0);
    send_word(24'd4000, -24'sd7000, 0);
    send_word(24'd5000, 24'd0, 1);
    // too few samples
    send_word(24'd0, 24'd5, 0);
    send_word(24'd1000, 24'd6, 0);
    send_word(24'd2000, 24'd7, 1);
    wait_idle();
    // undetermined direction
    set_config(52429, 45875, 1000, 1000000, 5000, 0, 1000000, 0);
    for (int i = 0; i < 5; i++) send_word(24'(i * 1000), 24'(1000 + i), i == 4);
    wait_idle();
    // more regions than kept, entry at the full peak, exit just above zero;
    // keep offering a second lap while the result side holds off
    set_config(65536, 1, 1000, 16777215, 1048575, 0, 16777215, 1);
    hold_asks++;
    run_lap(40, 2, 0);
    run_lap(8, 1, 0);
    wait_idle();
    // zero smoothing with wrap of the corner across the gate
    set_config(40000, 30000, 65535, 16777215, 0, 16000000, 800000, 2);
    run_lap(30, 1, 1);
    wait_idle();

    while (words_sent < 410) random_phase();

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d laps of %0d sample words, %0d result words checked.",
             laps_sent, words_sent, words_checked);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
